// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the vertex normal core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SVNA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SVNA_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define SVNA_ASSERT(lbl, clk, rst, prop, msg)
`define SVNA_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

// ===== rtl/core/svna_pkg.sv =====
// Package of the vertex normal core: widths, codes, state types.
package svna_pkg;

   localparam int VERTICES = 1024;
   localparam int IDX_W    = 10;
   localparam int POS_W    = 16;
   localparam int EDGE_W   = POS_W + 1;
   localparam int PROD_W   = 2 * EDGE_W;
   localparam int NVEC_W   = PROD_W + 1;
   localparam int ACC_W    = 24;
   localparam int UNIT_W   = 16;
   localparam int MAG_W    = 30;
   localparam int SUM_W    = 2 * MAG_W + 2;
   localparam int ROOT_W   = SUM_W / 2;
   localparam int SREM_W   = ROOT_W + 2;
   localparam int Q_W      = 15;
   localparam int NUM_W    = MAG_W + Q_W + 1;
   localparam int DREM_W   = ROOT_W + 2;
   localparam int CNT_W    = 5;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef enum logic [1:0] {
      FUNC_LOAD = 2'd0,
      FUNC_TRI  = 2'd1,
      FUNC_READ = 2'd2,
      FUNC_NONE = 2'd3
   } func_type;

   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic signed [POS_W-1:0]  pos_type;
   typedef logic signed [UNIT_W-1:0] unit_type;
   typedef logic signed [NVEC_W-1:0] nvec_type;

   typedef enum logic [3:0] {
      C_IDLE, C_TRI_RD, C_TRI_CROSS, C_TRI_START, C_TRI_NORM,
      C_ACC_RD, C_ACC_WR, C_RD_ACC, C_RD_START, C_RD_NORM, C_RD_OUT
   } core_state_type;

   typedef enum logic [2:0] {
      N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DIV_SET, N_DIV, N_DONE
   } norm_state_type;

   typedef struct packed {
      logic done;
      logic busy;
   } norm_stat_type;

endpackage

// ===== rtl/core/svna_ifs.sv =====
// Channel interfaces: request and response of the vertex normal core.
interface svna_req_if;
   import svna_pkg::*;
   logic    valid;
   logic    ready;
   logic [1:0] func;
   idx_type vertex_index;
   pos_type pos_x;
   pos_type pos_y;
   pos_type pos_z;
   logic signed [15:0] start_nx;
   logic signed [15:0] start_ny;
   logic signed [15:0] start_nz;
   idx_type corner_a;
   idx_type corner_b;
   idx_type corner_c;
   modport source (output valid, func, vertex_index, pos_x, pos_y, pos_z,
                   start_nx, start_ny, start_nz, corner_a, corner_b, corner_c,
                   input ready);
   modport sink (input valid, func, vertex_index, pos_x, pos_y, pos_z,
                 start_nx, start_ny, start_nz, corner_a, corner_b, corner_c,
                 output ready);
endinterface

interface svna_rsp_if;
   import svna_pkg::*;
   logic     valid;
   logic     ready;
   idx_type  out_index;
   unit_type unit_x;
   unit_type unit_y;
   unit_type unit_z;
   modport source (output valid, out_index, unit_x, unit_y, unit_z, input ready);
   modport sink (input valid, out_index, unit_x, unit_y, unit_z, output ready);
endinterface

// ===== rtl/core/smooth_vertex_normal_accumulator_core.sv =====
// Vertex normal core: position/accumulator memories, face normal and readout.
// Load: writes both memories on accept of an in-range index. Triangle: reads the three
// corner positions, forms the cross product, runs the normalizer, then 3 read-modify-write pairs.
// Read: reads the accumulator and runs the normalizer; requests are taken only in idle.
// The normalizer's bit-serial sqrt and three 15-step divides set the rate.
// Synchronous reset clears control state only; memories hold no reset value.
module smooth_vertex_normal_accumulator_core (
   input logic clock,
   input logic reset,
   svna_req_if.sink   req_ch,
   svna_rsp_if.source rsp_ch
);
   import svna_pkg::*;
`include "assert_macros.svh"

   localparam int PW = 3 * POS_W;
   localparam int AW = 3 * ACC_W;

   core_state_type state_ff, state_in;
   logic [1:0] cnt_ff;
   idx_type    vi_ff, ca_ff, cb_ff, cc_ff;
   pos_type    pa_ff [3], pb_ff [3], pc_ff [3];
   logic signed [PROD_W-1:0] p1_ff, p2_ff;
   nvec_type   n_ff [3];
   logic       rd_zero_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   idx_type    rsp_idx_ff;
   unit_type   rsp_u_ff [3];

   logic [PW-1:0] pos_mem [VERTICES];
   logic [AW-1:0] acc_mem [VERTICES];
   logic [PW-1:0] pos_q_ff, pos_wdata;
   logic [AW-1:0] acc_q_ff, acc_wdata;
   idx_type       pos_addr, acc_addr;
   logic          pos_we, acc_we;

   logic          req_take, tri_ok, rd_ok, out_take;
   logic signed [EDGE_W-1:0] e1 [3], e2 [3];
   logic signed [EDGE_W-1:0] x1, x2, y1, y2;
   logic          norm_start;
   nvec_type      norm_vec [3];
   unit_type      norm_unit [3];
   norm_stat_type norm_stat;
   idx_type       corner;
   logic signed [ACC_W:0] acc_sum [3];
   logic signed [ACC_W-1:0] acc_new [3];

   assign req_ch.ready = state_ff == C_IDLE;
   assign req_take = req_ch.valid && req_ch.ready;
   assign tri_ok = (32'(req_ch.corner_a) < VERTICES) && (32'(req_ch.corner_b) < VERTICES) &&
                   (32'(req_ch.corner_c) < VERTICES);
   assign rd_ok  = 32'(req_ch.vertex_index) < VERTICES;
   assign out_take = !rsp_valid_ff || rsp_ch.ready;

   // edges and cross product operand selection
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e1[i] = EDGE_W'(pb_ff[i]) - EDGE_W'(pa_ff[i]);
         e2[i] = EDGE_W'(pc_ff[i]) - EDGE_W'(pa_ff[i]);
      end
      case (cnt_ff)
         2'd0:    begin x1 = e1[1]; y2 = e2[2]; x2 = e1[2]; y1 = e2[1]; end
         2'd1:    begin x1 = e1[2]; y2 = e2[0]; x2 = e1[0]; y1 = e2[2]; end
         default: begin x1 = e1[0]; y2 = e2[1]; x2 = e1[1]; y1 = e2[0]; end
      endcase
   end

   // corner select and saturating accumulate
   always_comb begin
      case (cnt_ff)
         2'd0:    corner = ca_ff;
         2'd1:    corner = cb_ff;
         default: corner = cc_ff;
      endcase
      for (int i = 0; i < 3; i++) begin
         acc_sum[i] = (ACC_W+1)'($signed(acc_q_ff[i*ACC_W +: ACC_W])) +
                      (ACC_W+1)'(norm_unit[i]);
         if (acc_sum[i] > (ACC_W+1)'(ACC_MAX)) acc_new[i] = ACC_MAX;
         else if (acc_sum[i] < (ACC_W+1)'(ACC_MIN)) acc_new[i] = ACC_MIN;
         else acc_new[i] = acc_sum[i][ACC_W-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         C_IDLE: begin
            if (req_take) begin
               case (req_ch.func)
                  FUNC_TRI:  if (tri_ok) state_in = C_TRI_RD;
                  FUNC_READ: state_in = rd_ok ? C_RD_ACC : C_RD_OUT;
                  default:   state_in = C_IDLE;
               endcase
            end
         end
         C_TRI_RD:    if (cnt_ff == 2'd3) state_in = C_TRI_CROSS;
         C_TRI_CROSS: if (cnt_ff == 2'd3) state_in = C_TRI_START;
         C_TRI_START: state_in = C_TRI_NORM;
         C_TRI_NORM:  if (norm_stat.done) state_in = C_ACC_RD;
         C_ACC_RD:    state_in = C_ACC_WR;
         C_ACC_WR:    state_in = (cnt_ff == 2'd2) ? C_IDLE : C_ACC_RD;
         C_RD_ACC:    state_in = C_RD_START;
         C_RD_START:  state_in = C_RD_NORM;
         C_RD_NORM:   if (norm_stat.done) state_in = C_RD_OUT;
         C_RD_OUT:    if (out_take) state_in = C_IDLE;
         default:     state_in = C_IDLE;
      endcase
   end

   // memory control and normalizer start
   always_comb begin
      pos_we    = 1'b0;
      acc_we    = 1'b0;
      pos_addr  = ca_ff;
      acc_addr  = corner;
      pos_wdata = {req_ch.pos_z, req_ch.pos_y, req_ch.pos_x};
      acc_wdata = {ACC_W'(req_ch.start_nz), ACC_W'(req_ch.start_ny),
                   ACC_W'(req_ch.start_nx)};
      norm_start = 1'b0;
      for (int i = 0; i < 3; i++) norm_vec[i] = n_ff[i];
      case (state_ff)
         C_IDLE: begin
            pos_addr = req_ch.vertex_index;
            acc_addr = req_ch.vertex_index;
            if (req_take && req_ch.func == FUNC_LOAD && rd_ok) begin
               pos_we = 1'b1;
               acc_we = 1'b1;
            end
         end
         C_TRI_RD: begin
            case (cnt_ff)
               2'd0:    pos_addr = ca_ff;
               2'd1:    pos_addr = cb_ff;
               default: pos_addr = cc_ff;
            endcase
         end
         C_TRI_START: norm_start = 1'b1;
         C_ACC_WR: begin
            acc_we    = 1'b1;
            acc_wdata = {acc_new[2], acc_new[1], acc_new[0]};
         end
         C_RD_ACC: acc_addr = vi_ff;
         C_RD_START: begin
            norm_start = 1'b1;
            for (int i = 0; i < 3; i++)
               norm_vec[i] = NVEC_W'($signed(acc_q_ff[i*ACC_W +: ACC_W]));
         end
         default: ;
      endcase
   end

   // memories, registered read
   always_ff @(posedge clock) begin
      if (pos_we) pos_mem[pos_addr] <= pos_wdata;
      pos_q_ff <= pos_mem[pos_addr];
   end

   always_ff @(posedge clock) begin
      if (acc_we) acc_mem[acc_addr] <= acc_wdata;
      acc_q_ff <= acc_mem[acc_addr];
   end

   svna_norm u_norm (
      .clock    (clock),
      .reset    (reset),
      .start    (norm_start),
      .vec_in   (norm_vec),
      .unit_out (norm_unit),
      .stat     (norm_stat)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= C_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_in != state_ff && state_ff != C_ACC_RD && state_ff != C_ACC_WR)
            cnt_ff <= '0;
         else if (state_ff == C_TRI_RD || state_ff == C_TRI_CROSS)
            cnt_ff <= cnt_ff + 2'd1;
         else if (state_ff == C_ACC_WR)
            cnt_ff <= cnt_ff + 2'd1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ch.ready) rsp_valid_in = 1'b0;
      if (state_ff == C_RD_OUT && out_take) rsp_valid_in = 1'b1;
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         vi_ff      <= req_ch.vertex_index;
         ca_ff      <= req_ch.corner_a;
         cb_ff      <= req_ch.corner_b;
         cc_ff      <= req_ch.corner_c;
         rd_zero_ff <= !rd_ok;
      end
      if (state_ff == C_TRI_RD) begin
         for (int i = 0; i < 3; i++) begin
            if (cnt_ff == 2'd1) pa_ff[i] <= pos_q_ff[i*POS_W +: POS_W];
            if (cnt_ff == 2'd2) pb_ff[i] <= pos_q_ff[i*POS_W +: POS_W];
            if (cnt_ff == 2'd3) pc_ff[i] <= pos_q_ff[i*POS_W +: POS_W];
         end
      end
      if (state_ff == C_TRI_CROSS) begin
         if (cnt_ff != 2'd3) begin
            p1_ff <= x1 * y2;
            p2_ff <= x2 * y1;
         end
         if (cnt_ff != 2'd0) n_ff[cnt_ff - 2'd1] <= NVEC_W'(p1_ff) - NVEC_W'(p2_ff);
      end
      if (state_ff == C_RD_OUT && out_take) begin
         rsp_idx_ff <= vi_ff;
         for (int i = 0; i < 3; i++) rsp_u_ff[i] <= rd_zero_ff ? '0 : norm_unit[i];
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_index = rsp_idx_ff;
   assign rsp_ch.unit_x    = rsp_u_ff[0];
   assign rsp_ch.unit_y    = rsp_u_ff[1];
   assign rsp_ch.unit_z    = rsp_u_ff[2];

   // checks
   `SVNA_ASSERT(a_done_wait, clock, reset, norm_stat.done |-> (state_ff == C_TRI_NORM || state_ff == C_RD_NORM), "normalizer finished outside a wait state")
   `SVNA_ASSERT(a_rmw_order, clock, reset, (state_ff == C_ACC_WR) |-> ($past(state_ff) == C_ACC_RD), "accumulator write without a preceding read")
   `SVNA_NEVER(a_norm_busy, clock, reset, norm_start && norm_stat.busy, "normalizer started while busy")
   `SVNA_ASSERT(a_unit_range, clock, reset, norm_stat.done |-> (norm_unit[0] <= 16'sd16384 && norm_unit[0] >= -16'sd16384 && norm_unit[2] <= 16'sd16384 && norm_unit[2] >= -16'sd16384), "unit component out of range")

endmodule

// ===== rtl/core/svna_norm.sv =====
// Iterative normalizer: prescale, sum of squares, bit-serial sqrt and divide.
module svna_norm (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  svna_pkg::nvec_type   vec_in [3],
   output svna_pkg::unit_type   unit_out [3],
   output svna_pkg::norm_stat_type stat
);
   import svna_pkg::*;

   norm_state_type state_ff, state_in;
   logic [NVEC_W-1:0] mag_ff [3];
   logic              neg_ff [3];
   logic [CNT_W-1:0]  cnt_ff;
   logic [1:0]        comp_ff;
   logic [SUM_W-1:0]  prod_ff, sum_ff;
   logic [SREM_W-1:0] srem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [DREM_W-1:0] drem_ff;
   logic [Q_W-1:0]    dlow_ff, q_ff;
   unit_type          unit_ff [3];

   logic              big;
   logic [SREM_W-1:0] s_rem2, s_trial;
   logic              s_take;
   logic [DREM_W-1:0] d_rem2, d_den;
   logic              d_take;
   logic [Q_W-1:0]    d_q;
   logic [NUM_W-1:0]  num;

   // step logic of the shared units
   always_comb begin
      big     = (|mag_ff[0][NVEC_W-1:MAG_W]) | (|mag_ff[1][NVEC_W-1:MAG_W]) |
                (|mag_ff[2][NVEC_W-1:MAG_W]);
      s_rem2  = {srem_ff[SREM_W-3:0], sum_ff[SUM_W-1:SUM_W-2]};
      s_trial = {root_ff, 2'b01};
      s_take  = s_rem2 >= s_trial;
      d_rem2  = {drem_ff[DREM_W-2:0], dlow_ff[Q_W-1]};
      d_den   = {1'b0, root_ff, 1'b0};
      d_take  = d_rem2 >= d_den;
      d_q     = {q_ff[Q_W-2:0], d_take};
      num     = {1'b0, mag_ff[comp_ff][MAG_W-1:0], {Q_W{1'b0}}} +
                NUM_W'(root_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         N_IDLE:    if (start) state_in = N_SHIFT;
         N_SHIFT:   if (!big) state_in = N_SQ;
         N_SQ:      if (cnt_ff == CNT_W'(3)) state_in = N_SQRT;
         N_SQRT:    if (cnt_ff == CNT_W'(ROOT_W - 1)) state_in = N_DIV_SET;
         N_DIV_SET: if (root_ff == '0) state_in = N_DONE;
                    else state_in = N_DIV;
         N_DIV: begin
            if (cnt_ff == CNT_W'(Q_W - 1))
               state_in = (comp_ff == 2'd2) ? N_DONE : N_DIV_SET;
         end
         N_DONE:    state_in = N_IDLE;
         default:   state_in = N_IDLE;
      endcase
   end

   // status outputs
   always_comb begin
      stat.done = state_ff == N_DONE;
      stat.busy = state_ff != N_IDLE;
      unit_out  = unit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= N_IDLE;
      else state_ff <= state_in;
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         N_IDLE: begin
            for (int i = 0; i < 3; i++) begin
               neg_ff[i] <= vec_in[i][NVEC_W-1];
               mag_ff[i] <= vec_in[i][NVEC_W-1] ? NVEC_W'(-vec_in[i]) : vec_in[i];
            end
            cnt_ff <= '0;
            sum_ff <= '0;
         end
         N_SHIFT: begin
            if (big) begin
               for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] >> 1;
            end
         end
         N_SQ: begin
            if (cnt_ff != CNT_W'(3))
               prod_ff <= SUM_W'(mag_ff[cnt_ff[1:0]][MAG_W-1:0] *
                                 mag_ff[cnt_ff[1:0]][MAG_W-1:0]);
            if (cnt_ff != '0) sum_ff <= sum_ff + prod_ff;
            cnt_ff  <= (cnt_ff == CNT_W'(3)) ? '0 : cnt_ff + CNT_W'(1);
            srem_ff <= '0;
            root_ff <= '0;
         end
         N_SQRT: begin
            srem_ff <= s_take ? s_rem2 - s_trial : s_rem2;
            root_ff <= {root_ff[ROOT_W-2:0], s_take};
            sum_ff  <= sum_ff << 2;
            cnt_ff  <= (cnt_ff == CNT_W'(ROOT_W - 1)) ? '0 : cnt_ff + CNT_W'(1);
            comp_ff <= '0;
         end
         N_DIV_SET: begin
            drem_ff <= DREM_W'(num[NUM_W-1:Q_W]);
            dlow_ff <= num[Q_W-1:0];
            q_ff    <= '0;
            cnt_ff  <= '0;
            if (root_ff == '0) begin
               for (int i = 0; i < 3; i++) unit_ff[i] <= '0;
            end
         end
         N_DIV: begin
            drem_ff <= d_take ? d_rem2 - d_den : d_rem2;
            dlow_ff <= dlow_ff << 1;
            q_ff    <= d_q;
            cnt_ff  <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(Q_W - 1)) begin
               unit_ff[comp_ff] <= neg_ff[comp_ff] ? -$signed({1'b0, d_q})
                                                   : $signed({1'b0, d_q});
               comp_ff <= comp_ff + 2'd1;
            end
         end
         default: ;
      endcase
   end

endmodule
